[rtl/dsg_pkg.sv]
// Package of the decaying sine generator: configuration record, register indexes,
// reset values, parameter defaults and the fixed-point sine coefficients.
// Depends on nothing; every other file of the block imports it.
package dsg_pkg;

    // Parameter defaults handed to the top level.
    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_SAMPLE_WIDTH     = 24;

    // Depth of the two queues around the sample engine.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_AMPLITUDE    = 2'd0,
        CFG_PHASE_STEP   = 2'd1,
        CFG_DECAY_FACTOR = 2'd2,
        CFG_RUN_LENGTH   = 2'd3
    } t_cfg_index;

    // Configuration registers as seen by the sample engine.
    typedef struct packed {
        logic [15:0] amplitude;
        logic [30:0] phase_step;
        logic [31:0] decay_factor;
        logic [24:0] run_length;
    } t_cfg;

    localparam logic [15:0] RST_AMPLITUDE    = 16'd32768;
    localparam logic [30:0] RST_PHASE_STEP   = 31'd39370534;
    localparam logic [31:0] RST_DECAY_FACTOR = 32'd4294143246;
    localparam logic [24:0] RST_RUN_LENGTH   = 25'd48000;

    // Envelope of 1.0 in Q1.31.
    localparam logic [31:0] ENV_ONE = 32'h8000_0000;

    // Odd polynomial for the sine of a quarter turn, Q2.30.
    localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
    localparam logic signed [35:0] COEF_A1 = 36'sd1686629713;
    localparam logic signed [35:0] COEF_A3 = 36'sd693598668;
    localparam logic signed [35:0] COEF_A5 = 36'sd85569306;
    localparam logic [31:0]        COEF_A7 = 32'd4858527;

endpackage

[rtl/dsg_fifo.sv]
// Small first-in first-out queue used on both sides of the sample engine.
// Uses dsg_pkg for the default depth.
module dsg_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = dsg_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import dsg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage of the words; no reset needed.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/dsg_core.sv]
// Sample engine: run state, sine polynomial, amplitude and envelope scaling, all on
// one shared 32x32 multiplier sequenced over cycles. Uses dsg_pkg.
module dsg_core #(
    parameter int SINE_TABLE_DEPTH = dsg_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH     = dsg_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dsg_pkg::t_cfg           i_cfg,
    input  logic                    i_in_valid,
    input  logic                    i_in_restart,
    output logic                    o_in_pop,
    input  logic                    i_out_full,
    output logic                    o_out_push,
    output logic [SAMPLE_WIDTH-1:0] o_out_sample,
    output logic [SAMPLE_WIDTH-2:0] o_out_peak,
    output logic                    o_out_last
);
    import dsg_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int TBL_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int RND_SH   = 31 - SW;
    localparam logic [29:0] X_MASK   = ~30'((64'd1 << (32 - TBL_BITS)) - 64'd1);
    localparam logic [34:0] POS_MAX  = (35'd1 << (SW - 1)) - 35'd1;
    localparam logic [34:0] NEG_MAX  = 35'd1 << (SW - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_WB     = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    // Products in the order they are formed for one sample.
    typedef enum logic [2:0] {
        OP_X2  = 3'd0,
        OP_P1  = 3'd1,
        OP_P2  = 3'd2,
        OP_P3  = 3'd3,
        OP_P4  = 3'd4,
        OP_M1  = 3'd5,
        OP_M2  = 3'd6,
        OP_ENV = 3'd7
    } t_op;

    t_state r_state, n_state;
    t_op    r_op;

    // Run state.
    logic [31:0]   r_phase;
    logic [31:0]   r_env;
    logic [24:0]   r_idx;
    logic [SW-2:0] r_peak;

    // Working registers of one sample.
    logic [30:0] r_x;
    logic [30:0] r_x2;
    logic        r_neg;
    logic        r_sign;
    logic [31:0] r_opnd;
    logic [63:0] r_prod;
    logic [34:0] r_scaled;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [29:0] x30;
    logic [33:0] poly_t;
    logic signed [35:0] poly_term;
    logic signed [35:0] poly_const;
    logic signed [35:0] poly_sum;
    logic [35:0] poly_abs;
    logic [32:0] m2;
    logic [34:0] m2_round;
    logic [34:0] clamped;
    logic [SW-2:0] peak_mag;
    logic [SW-2:0] peak_next;
    logic          run_done;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_op) inside
            OP_X2: begin
                mul_a = {1'b0, r_x};
                mul_b = {1'b0, r_x};
            end
            OP_P1, OP_P2, OP_P3: begin
                mul_a = r_opnd;
                mul_b = {1'b0, r_x2};
            end
            OP_P4: begin
                mul_a = r_opnd;
                mul_b = {1'b0, r_x};
            end
            OP_M1: begin
                mul_a = {16'd0, i_cfg.amplitude};
                mul_b = r_opnd;
            end
            OP_M2: begin
                mul_a = r_opnd;
                mul_b = r_env;
            end
            OP_ENV: begin
                mul_a = r_env;
                mul_b = i_cfg.decay_factor;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Quarter-turn angle of the quantized phase; it is mirrored in odd quadrants in r_x.
    assign x30 = r_phase[29:0] & X_MASK;

    // Polynomial step: signed accumulator times Q30 value, truncated toward zero.
    assign poly_t    = r_prod[63:30];
    assign poly_term = r_sign ? -$signed({2'b00, poly_t}) : $signed({2'b00, poly_t});

    always_comb begin
        unique case (r_op) inside
            OP_P1:   poly_const = COEF_A5;
            OP_P2:   poly_const = -COEF_A3;
            OP_P3:   poly_const = COEF_A1;
            default: poly_const = '0;
        endcase
    end

    assign poly_sum = poly_const + poly_term;
    assign poly_abs = poly_sum[35] ? 36'(-poly_sum) : 36'(poly_sum);

    // Round the Q30 magnitude half up to the sample precision.
    assign m2 = r_prod[63:31];

    generate
        if (RND_SH > 0) begin : g_round
            assign m2_round = ({2'b00, m2} + (35'd1 << (RND_SH - 1))) >> RND_SH;
        end else if (RND_SH == 0) begin : g_exact
            assign m2_round = {2'b00, m2};
        end else begin : g_widen
            assign m2_round = {1'b0, m2, 1'b0};
        end
    endgenerate

    // Saturation of the final sample and the running peak.
    always_comb begin
        if (r_neg) begin
            clamped = (r_scaled > NEG_MAX) ? NEG_MAX : r_scaled;
        end else begin
            clamped = (r_scaled > POS_MAX) ? POS_MAX : r_scaled;
        end
        peak_mag  = (clamped > POS_MAX) ? POS_MAX[SW-2:0] : clamped[SW-2:0];
        peak_next = (peak_mag > r_peak) ? peak_mag : r_peak;
    end

    assign run_done     = (r_idx >= i_cfg.run_length);
    assign o_in_pop     = (r_state == ST_IDLE) && i_in_valid && !i_out_full;
    assign o_out_push   = (r_state == ST_FINISH);
    assign o_out_sample = r_neg ? ({SW{1'b0}} - clamped[SW-1:0]) : clamped[SW-1:0];
    assign o_out_peak   = peak_next;
    assign o_out_last   = ((r_idx + 25'd1) == i_cfg.run_length);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_in_pop) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = run_done ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                n_state = (r_op == OP_ENV) ? ST_FINISH : ST_MUL;
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Run state: cleared by reset and by a restart word, advanced per sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_env   <= ENV_ONE;
            r_idx   <= '0;
            r_peak  <= '0;
        end else begin
            if (o_in_pop && i_in_restart) begin
                r_phase <= '0;
                r_env   <= ENV_ONE;
                r_idx   <= '0;
                r_peak  <= '0;
            end
            if (r_state == ST_WB && r_op == OP_ENV) begin
                r_env <= r_prod[63:32];
            end
            if (r_state == ST_FINISH) begin
                r_peak  <= peak_next;
                r_idx   <= r_idx + 25'd1;
                r_phase <= r_phase + {1'b0, i_cfg.phase_step};
            end
        end
    end

    // Working registers of the multiply sequence.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CHECK: begin
                r_x    <= r_phase[30] ? (31'h4000_0000 - {1'b0, x30}) : {1'b0, x30};
                r_neg  <= r_phase[31];
                r_opnd <= COEF_A7;
                r_sign <= 1'b1;
                r_op   <= OP_X2;
            end
            ST_MUL: begin
                r_prod <= prod;
            end
            ST_WB: begin
                unique case (r_op) inside
                    OP_X2: begin
                        r_x2 <= r_prod[60:30];
                    end
                    OP_P1, OP_P2, OP_P3: begin
                        r_sign <= poly_sum[35];
                        r_opnd <= poly_abs[31:0];
                    end
                    OP_P4: begin
                        if (poly_sum[35]) begin
                            r_opnd <= '0;
                        end else if (poly_sum > Q30_ONE) begin
                            r_opnd <= Q30_ONE[31:0];
                        end else begin
                            r_opnd <= poly_sum[31:0];
                        end
                    end
                    OP_M1: begin
                        r_opnd <= r_prod[46:15];
                    end
                    OP_M2: begin
                        r_scaled <= m2_round;
                    end
                    OP_ENV: begin
                        r_scaled <= r_scaled;
                    end
                endcase
                if (r_op != OP_ENV) begin
                    r_op <= t_op'(r_op + 3'd1);
                end
            end
            default: begin
                r_op <= r_op;
            end
        endcase
    end

    // A result word is only written into the result queue when it has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result word written into a full result queue");

    // The envelope starts at 1.0 and only decays.
    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= ENV_ONE)
        else $error("envelope above 1.0");

    // The sine magnitude leaving the polynomial is clamped to 1.0.
    a_sine_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && r_op == OP_P4) |=> (r_opnd <= Q30_ONE[31:0]))
        else $error("sine magnitude above 1.0");

    // After the final sample of a run the sample count equals the run length.
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_last) |=> (r_idx == i_cfg.run_length))
        else $error("sample count does not match run length after last sample");

endmodule

[rtl/decaying_sine_generator.sv]
// Top level of the decaying sine generator: configuration registers, tick queue,
// sample engine and result queue. Uses dsg_pkg, dsg_fifo and dsg_core.
//
// Each tick word pushed in produces one sample word of an exponentially damped
// sine, or nothing once the run of run_length samples is over; a tick with restart
// set first clears phase, envelope, sample count and peak. A tick that yields a
// sample occupies the engine while the single 32x32 multiplier forms the eight
// products of a sample one after another, each product registered before it is
// used; a tick after the end of the run forms none. The engine takes a new tick
// only when it is through with the last. Two tick words and two result words can
// wait in the queues, so pushing and popping run independently of the engine.
// SINE_TABLE_DEPTH must be a power of two. Configuration writes take effect from
// the next tick and are meant to be made while no tick is waiting or in work.
module decaying_sine_generator #(
    parameter int SINE_TABLE_DEPTH = dsg_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH     = dsg_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [dsg_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [dsg_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_restart,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_value,
    output logic [SAMPLE_WIDTH-2:0]             o_peak_level,
    output logic                                o_last_sample
);
    import dsg_pkg::*;

    localparam int OUT_WIDTH = 2 * SAMPLE_WIDTH;

    t_cfg r_cfg;

    logic                    in_empty;
    logic                    in_restart;
    logic                    in_pop;
    logic                    out_full;
    logic                    out_push;
    logic [SAMPLE_WIDTH-1:0] out_sample;
    logic [SAMPLE_WIDTH-2:0] out_peak;
    logic                    out_last;
    logic [OUT_WIDTH-1:0]    out_word;

    // Configuration registers, masked to their widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amplitude    <= RST_AMPLITUDE;
            r_cfg.phase_step   <= RST_PHASE_STEP;
            r_cfg.decay_factor <= RST_DECAY_FACTOR;
            r_cfg.run_length   <= RST_RUN_LENGTH;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_AMPLITUDE:    r_cfg.amplitude    <= i_cfg_data[15:0];
                CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_data[30:0];
                CFG_DECAY_FACTOR: r_cfg.decay_factor <= i_cfg_data[31:0];
                CFG_RUN_LENGTH:   r_cfg.run_length   <= i_cfg_data[24:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    // Tick queue in front of the engine.
    dsg_fifo #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_restart),
        .o_full  (full),
        .i_pop   (in_pop),
        .o_data  (in_restart),
        .o_empty (in_empty)
    );

    // Sample engine.
    dsg_core #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (!in_empty),
        .i_in_restart (in_restart),
        .o_in_pop     (in_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out_sample (out_sample),
        .o_out_peak   (out_peak),
        .o_out_last   (out_last)
    );

    // Result queue behind the engine.
    dsg_fifo #(
        .WIDTH (OUT_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  ({out_sample, out_peak, out_last}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_word),
        .o_empty (empty)
    );

    assign o_sample_value = $signed(out_word[OUT_WIDTH-1 -: SAMPLE_WIDTH]);
    assign o_peak_level   = out_word[SAMPLE_WIDTH-1:1];
    assign o_last_sample  = out_word[0];

endmodule
